### sv/ffa_pkg.sv
// shared types, status and command codes for the first-fit allocator
// no dependencies; used by ffa_cell and first_fit_free_list_allocator_core
package ffa_pkg;

   // widths of the table fields carried between cells
   localparam int IDX_BITS = 10;
   localparam int RANK_BITS = 10;

   // action codes
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE = 1'b1;

   // status codes
   localparam logic [2:0] ST_REUSED = 3'd0;
   localparam logic [2:0] ST_GROWN = 3'd1;
   localparam logic [2:0] ST_ZERO = 3'd2;
   localparam logic [2:0] ST_TOO_LARGE = 3'd3;
   localparam logic [2:0] ST_TABLE_FULL = 3'd4;
   localparam logic [2:0] ST_FREED = 3'd5;
   localparam logic [2:0] ST_NULL = 3'd6;
   localparam logic [2:0] ST_BAD_FREE = 3'd7;

   // register indexes
   localparam logic [3:0] REG_HEAP_BASE = 4'd0;
   localparam logic [3:0] REG_HEAP_LIMIT = 4'd1;

   typedef struct packed {
      logic        action;
      logic [31:0] request_bytes;
      logic [31:0] payload_address;
   } req_word_type;

   typedef struct packed {
      logic [31:0] granted_address;
      logic [2:0]  status;
   } rsp_word_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic                 valid;
      logic                 found;
      logic                 is_free;
      logic [IDX_BITS-1:0]  idx;
      logic [RANK_BITS-1:0] rank;
      logic [31:0]          pay;
   } token_type;

   typedef enum logic [1:0] {
      CMD_NONE    = 2'd0,
      CMD_REUSE   = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_GROW    = 2'd3
   } cmd_kind_type;

   // table update broadcast to all cells
   typedef struct packed {
      cmd_kind_type         kind;
      logic [IDX_BITS-1:0]  idx;
      logic [RANK_BITS-1:0] rank;
      logic [31:0]          offset;
      logic [31:0]          size;
   } cmd_type;

   // payload address of a block, wrapped to the address width
   function automatic logic [31:0] payload_of(input logic [31:0] base,
                                              input logic [31:0] off,
                                              input logic [8:0]  hdr,
                                              input logic [6:0]  abits);
      logic [31:0] s;
      logic [31:0] m;
      s = base + off + {23'd0, hdr};
      if (abits < 7'd32) begin
         m = 32'hFFFF_FFFF >> (6'd32 - abits[5:0]);
      end else begin
         m = 32'hFFFF_FFFF;
      end
      return s & m;
   endfunction

endpackage

### sv/first_fit_free_list_allocator_core.sv
// first-fit free-list allocator: sequencer, growth logic and a row of ffa_cell
// depends on ffa_pkg and ffa_cell
//
// channel  ports                                  direction
// request  start, busy, req_word                  in, busy out
// result   rsp_valid, rsp_word                    out, one-cycle strobe
// config   csr_valid, csr_ready, csr_index, csr_data  in, csr_ready out
//
// after start is taken, a search token walks the row of cells one cell per
// cycle, then the last token is resolved into the registered result. the
// table update is registered with the result and lands before a new token
// reaches cell zero. synchronous reset clears the used and free flags of the table.
// the result cannot be stalled; a new start is taken while it is shown.
module first_fit_free_list_allocator_core #(
   parameter int MAX_BLOCKS = 64,
   parameter int HEADER_BYTES = 32,
   parameter int ADDR_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ffa_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output ffa_pkg::rsp_word_type rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [3:0]            csr_index,
   input  logic [31:0]           csr_data
);
   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int EW = $clog2(MAX_BLOCKS + 1);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   ffa_pkg::req_word_type word_ff;
   logic [31:0]           base_ff, limit_ff;
   logic [31:0]           break_ff, break_in;
   logic [EW-1:0]         made_ff, made_in;
   logic                  seed_ff;
   ffa_pkg::cmd_type      cmd_ff, cmd_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ffa_pkg::rsp_word_type rsp_ff, rsp_in;
   ffa_pkg::token_type    chain [MAX_BLOCKS+1];
   ffa_pkg::token_type    last;
   logic [33:0]           grow_end;
   logic                  accept;

   assign busy = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;
   assign last = chain[MAX_BLOCKS];

   // seed token for cell zero
   always_comb begin
      chain[0] = '0;
      chain[0].valid = seed_ff;
   end

   // row of cells
   for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
      ffa_cell #(
         .INDEX(g),
         .MAX_BLOCKS(MAX_BLOCKS),
         .HEADER_BYTES(HEADER_BYTES),
         .ADDR_BITS(ADDR_BITS)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .tok_in(chain[g]),
         .tok_out(chain[g+1]),
         .op(word_ff.action),
         .req_bytes(word_ff.request_bytes),
         .addr(word_ff.payload_address),
         .base(base_ff),
         .cmd(cmd_ff)
      );
   end

   assign grow_end = {2'b00, break_ff} + 34'(HEADER_BYTES) + {2'b00, word_ff.request_bytes};

   // sequencer and resolve
   always_comb begin
      state_in = state_ff;
      break_in = break_ff;
      made_in = made_ff;
      cmd_in = '0;
      cmd_in.kind = ffa_pkg::CMD_NONE;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (last.valid) begin
               state_in = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in.granted_address = '0;
               if (word_ff.action == ffa_pkg::ACT_ALLOC) begin
                  if (word_ff.request_bytes == '0) begin
                     rsp_in.status = ffa_pkg::ST_ZERO;
                  end else if (last.found) begin
                     rsp_in.status = ffa_pkg::ST_REUSED;
                     rsp_in.granted_address = last.pay;
                     cmd_in.kind = ffa_pkg::CMD_REUSE;
                     cmd_in.idx = last.idx;
                     cmd_in.rank = last.rank;
                  end else if (grow_end > {2'b00, limit_ff}) begin
                     rsp_in.status = ffa_pkg::ST_TOO_LARGE;
                  end else if (made_ff >= EW'(MAX_BLOCKS)) begin
                     rsp_in.status = ffa_pkg::ST_TABLE_FULL;
                  end else begin
                     rsp_in.status = ffa_pkg::ST_GROWN;
                     rsp_in.granted_address = ffa_pkg::payload_of(
                        base_ff, break_ff, 9'(HEADER_BYTES), 7'(ADDR_BITS));
                     cmd_in.kind = ffa_pkg::CMD_GROW;
                     cmd_in.idx = ffa_pkg::IDX_BITS'(made_ff[IW-1:0]);
                     cmd_in.offset = break_ff;
                     cmd_in.size = word_ff.request_bytes;
                     break_in = grow_end[31:0];
                     made_in = made_ff + EW'(1);
                  end
               end else begin
                  if (word_ff.payload_address == '0) begin
                     rsp_in.status = ffa_pkg::ST_NULL;
                  end else if (!last.found || last.is_free) begin
                     rsp_in.status = ffa_pkg::ST_BAD_FREE;
                  end else begin
                     rsp_in.status = ffa_pkg::ST_FREED;
                     cmd_in.kind = ffa_pkg::CMD_RELEASE;
                     cmd_in.idx = last.idx;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         break_ff <= '0;
         made_ff <= '0;
         seed_ff <= 1'b0;
         cmd_ff <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff <= '0;
         limit_ff <= 32'd65536;
      end else begin
         state_ff <= state_in;
         break_ff <= break_in;
         made_ff <= made_in;
         seed_ff <= accept;
         cmd_ff <= cmd_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ffa_pkg::REG_HEAP_BASE: base_ff <= csr_data;
               ffa_pkg::REG_HEAP_LIMIT: limit_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // request word and result word
   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= req_word;
      end
      rsp_ff <= rsp_in;
   end

endmodule

### sv/ffa_cell.sv
// one block table entry with its free-order rank and a search stage
// depends on ffa_pkg
module ffa_cell #(
   parameter int INDEX = 0,
   parameter int MAX_BLOCKS = 64,
   parameter int HEADER_BYTES = 32,
   parameter int ADDR_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  ffa_pkg::token_type  tok_in,
   output ffa_pkg::token_type  tok_out,
   input  logic                op,
   input  logic [31:0]         req_bytes,
   input  logic [31:0]         addr,
   input  logic [31:0]         base,
   input  ffa_pkg::cmd_type    cmd
);
   localparam int RW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

   logic [31:0]        offset_ff, offset_in;
   logic [31:0]        size_ff, size_in;
   logic               free_ff, free_in;
   logic               used_ff, used_in;
   logic [RW-1:0]      rank_ff, rank_in;
   ffa_pkg::token_type tok_ff, tok_in_nx;
   logic [31:0]        pay;
   logic               is_me;

   assign pay = ffa_pkg::payload_of(base, offset_ff, 9'(HEADER_BYTES), 7'(ADDR_BITS));
   assign is_me = (cmd.idx == ffa_pkg::IDX_BITS'(INDEX));
   assign tok_out = tok_ff;

   // search stage
   always_comb begin
      tok_in_nx = tok_in;
      if (tok_in.valid) begin
         if (op == ffa_pkg::ACT_ALLOC) begin
            if (free_ff && size_ff >= req_bytes &&
                (!tok_in.found || ffa_pkg::RANK_BITS'(rank_ff) < tok_in.rank)) begin
               tok_in_nx.found = 1'b1;
               tok_in_nx.idx = ffa_pkg::IDX_BITS'(INDEX);
               tok_in_nx.rank = ffa_pkg::RANK_BITS'(rank_ff);
               tok_in_nx.is_free = free_ff;
               tok_in_nx.pay = pay;
            end
         end else if (used_ff && pay == addr && !tok_in.found) begin
            tok_in_nx.found = 1'b1;
            tok_in_nx.idx = ffa_pkg::IDX_BITS'(INDEX);
            tok_in_nx.rank = ffa_pkg::RANK_BITS'(rank_ff);
            tok_in_nx.is_free = free_ff;
            tok_in_nx.pay = pay;
         end
      end
   end

   // table updates
   always_comb begin
      offset_in = offset_ff;
      size_in = size_ff;
      free_in = free_ff;
      used_in = used_ff;
      rank_in = rank_ff;
      case (cmd.kind)
         ffa_pkg::CMD_REUSE: begin
            if (is_me) begin
               free_in = 1'b0;
            end else if (free_ff && ffa_pkg::RANK_BITS'(rank_ff) > cmd.rank) begin
               rank_in = rank_ff - RW'(1);
            end
         end
         ffa_pkg::CMD_RELEASE: begin
            if (is_me) begin
               free_in = 1'b1;
               rank_in = '0;
            end else if (free_ff) begin
               rank_in = rank_ff + RW'(1);
            end
         end
         ffa_pkg::CMD_GROW: begin
            if (is_me) begin
               offset_in = cmd.offset;
               size_in = cmd.size;
               free_in = 1'b0;
               used_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= 1'b0;
         used_ff <= 1'b0;
         tok_ff <= '0;
      end else begin
         free_ff <= free_in;
         used_ff <= used_in;
         tok_ff <= tok_in_nx;
      end
   end

   // entry payload
   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
      size_ff <= size_in;
      rank_ff <= rank_in;
   end

endmodule
